// ----- rtl/crc8cfr_pkg.sv -----
// Shared types, constants and the CRC-8 fold function for the frame receiver.
`default_nettype none

package crc8cfr_pkg;

    localparam int MAX_FRAME_DEF = 64;
    // byte_offset is six bits wide, so a frame never runs past 64 bytes.
    localparam int OFFSET_LIMIT  = 64;

    localparam logic [7:0] HEADER_RESET = 8'hA5;
    localparam logic [6:0] LENGTH_RESET = 7'd64;
    localparam logic [6:0] LENGTH_MIN   = 7'd2;
    localparam logic [7:0] SEED_RESET   = 8'hFF;
    localparam logic [7:0] CRC_POLY     = 8'h8C;  // reflected Dallas/Maxim polynomial

    typedef enum logic [1:0] {
        CFG_HEADER = 2'd0,
        CFG_LENGTH = 2'd1,
        CFG_SEED   = 2'd2,
        CFG_SPARE  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] header_value;
        logic [6:0] frame_length;
        logic [7:0] crc_seed;
    } t_cfg;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [5:0] byte_offset;
        logic       last;
        logic       crc_ok;
    } t_result;

    typedef enum logic {
        ST_HUNT  = 1'b0,
        ST_FRAME = 1'b1
    } t_rx_state;

    // One byte through the reflected CRC-8, LSB first.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/crc8cfr_cfg_regs.sv -----
// Configuration registers of the frame receiver.
`default_nettype none

module crc8cfr_cfg_regs
    import crc8cfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_value <= HEADER_RESET;
            r_cfg.frame_length <= LENGTH_RESET;
            r_cfg.crc_seed     <= SEED_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_HEADER: r_cfg.header_value <= i_cfg_data;
                CFG_LENGTH: r_cfg.frame_length <= i_cfg_data[6:0];
                CFG_SEED:   r_cfg.crc_seed     <= i_cfg_data;
                default:    ;  // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/crc8cfr_frame_fsm.sv -----
// Hunt/frame state machine with running CRC and byte counter.
`default_nettype none

module crc8cfr_frame_fsm
    import crc8cfr_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_cfg            i_cfg,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam int LEN_CAP = (MAX_FRAME < OFFSET_LIMIT) ? MAX_FRAME : OFFSET_LIMIT;

    t_rx_state  r_state, n_state;
    logic [5:0] r_byte_count, n_byte_count;
    logic [7:0] r_crc, n_crc;

    logic [6:0] len_used;
    logic [5:0] final_pos;
    logic [5:0] offset;
    logic       at_end;
    logic       is_header;

    always_comb begin
        len_used = i_cfg.frame_length;
        if (len_used > 7'(LEN_CAP)) begin
            len_used = 7'(LEN_CAP);
        end
        if (len_used < LENGTH_MIN) begin
            len_used = LENGTH_MIN;
        end
    end

    assign final_pos = 6'(len_used - 7'd1);
    assign offset    = r_byte_count + 6'd1;
    assign at_end    = (offset >= final_pos);
    assign is_header = (i_byte == i_cfg.header_value);

    // next state
    always_comb begin
        n_state      = r_state;
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        if (i_step) begin
            case (r_state)
                ST_HUNT: begin
                    if (is_header) begin
                        n_state      = ST_FRAME;
                        n_byte_count = '0;
                        n_crc        = crc8_fold(i_cfg.crc_seed, i_byte);
                    end
                end
                ST_FRAME: begin
                    n_byte_count = offset;
                    if (at_end) begin
                        n_state = ST_HUNT;
                    end else begin
                        n_crc = crc8_fold(r_crc, i_byte);
                    end
                end
                default: n_state = ST_HUNT;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_res_valid      = 1'b0;
        o_res.payload_byte = i_byte;
        o_res.byte_offset  = offset;
        o_res.last         = 1'b0;
        o_res.crc_ok       = 1'b0;
        case (r_state)
            ST_FRAME: begin
                o_res_valid  = i_step;
                o_res.last   = at_end;
                o_res.crc_ok = at_end && (r_crc == i_byte);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_HUNT;
            r_byte_count <= '0;
            r_crc        <= '0;
        end else begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
        end
    end

    a_res_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_state == ST_FRAME))
        else $error("result produced while hunting");

    a_last_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> (r_state == ST_HUNT))
        else $error("frame did not end after last byte");

    a_header_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_state == ST_HUNT && is_header) |=>
            (r_state == ST_FRAME && r_byte_count == 6'd0))
        else $error("header byte did not open a frame");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_state == ST_FRAME) |=> (r_byte_count == $past(offset)))
        else $error("byte counter did not advance");

endmodule

`default_nettype wire

// ----- rtl/crc8_checked_frame_receiver.sv -----
// Top level of the CRC-8 checked frame receiver.
`default_nettype none

//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_data_byte
//  out     | output    | o_out_valid / i_out_stall| o_payload_byte, o_byte_offset,
//          |           |                          | o_last, o_crc_ok
//  cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
//  One byte per cycle sustained while the output is not stalled. A byte transfer lands
//  in the input register; from there it passes the hunt/frame logic and one CRC fold
//  step into the output register, where any result it yields is offered.
//  Synchronous active-low reset clears both valid flags and puts the receiver in hunt.
//  A stall on the output holds both registers; o_in_stall then rises only once the
//  input register is also occupied.

module crc8_checked_frame_receiver
    import crc8cfr_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte input
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    // result output
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_payload_byte,
    output logic [5:0]      o_byte_offset,
    output logic            o_last,
    output logic            o_crc_ok,
    // configuration writes
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_cfg    cfg;
    t_result res;
    logic    res_valid;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic out_free;   // output register can load this cycle
    logic step;       // input register item is consumed this cycle

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    crc8cfr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    crc8cfr_frame_fsm #(
        .MAX_FRAME (MAX_FRAME)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // input register: takes a transfer whenever it is empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
        end
    end

    // output register: hunted bytes and the header leave no result behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out.payload_byte;
    assign o_byte_offset  = r_out.byte_offset;
    assign o_last         = r_out.last;
    assign o_crc_ok       = r_out.crc_ok;

endmodule

`default_nettype wire

// ----- tb/crc8cfr_checker.sv -----
// Transfer monitor, CRC-8 deframer predictor and result checker for the frame receiver.
`timescale 1ns / 100ps

module crc8cfr_checker
    import crc8cfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       o_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] o_payload_byte,
    input  wire logic [5:0] o_byte_offset,
    input  wire logic       o_last,
    input  wire logic       o_crc_ok,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);

    localparam int FRAME_CAP = 64;

    logic [7:0] crc_tab [256];
    t_cfg       cfg;
    t_rx_state  rx_state;
    logic [5:0] frame_pos;
    logic [7:0] crc_acc;
    t_result    queued_payloads [$];

    initial begin
        logic [7:0] c;
        for (int v = 0; v < 256; v++) begin
            c = 8'(v);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            crc_tab[v] = c;
        end
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // One received byte through the deframer; queues the result it yields, if any.
    task automatic deframe_byte(input logic [7:0] b);
        t_result r;
        logic [5:0] off;
        int len;
        if (rx_state == ST_HUNT) begin
            if (b == cfg.header_value) begin
                rx_state  = ST_FRAME;
                frame_pos = '0;
                crc_acc   = crc_tab[cfg.crc_seed ^ b];
            end
        end else begin
            len = int'(cfg.frame_length);
            if (len > FRAME_CAP) len = FRAME_CAP;
            if (len < 2) len = 2;
            off            = frame_pos + 6'd1;
            r.payload_byte = b;
            r.byte_offset  = off;
            if (int'(off) >= len - 1) begin
                r.last   = 1'b1;
                r.crc_ok = (crc_acc == b);
                rx_state = ST_HUNT;
            end else begin
                r.last   = 1'b0;
                r.crc_ok = 1'b0;
                crc_acc  = crc_tab[crc_acc ^ b];
            end
            frame_pos = off;
            queued_payloads.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg.header_value = HEADER_RESET;
            cfg.frame_length = LENGTH_RESET;
            cfg.crc_seed     = SEED_RESET;
            rx_state         = ST_HUNT;
            frame_pos        = '0;
            crc_acc          = '0;
            queued_payloads.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_HEADER: cfg.header_value = i_cfg_data;
                    CFG_LENGTH: cfg.frame_length = i_cfg_data[6:0];
                    CFG_SEED:   cfg.crc_seed     = i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                deframe_byte(i_data_byte);
            end
            if (o_out_valid && !i_out_stall) begin
                if (queued_payloads.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte %02h offset %0d",
                                              o_payload_byte, o_byte_offset));
                end else begin
                    want = queued_payloads.pop_front();
                    o_checked++;
                    if (o_payload_byte !== want.payload_byte)
                        report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                                  o_payload_byte, want.payload_byte));
                    if (o_byte_offset !== want.byte_offset)
                        report_mismatch($sformatf("byte_offset %0d, expected %0d",
                                                  o_byte_offset, want.byte_offset));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b at offset %0d",
                                                  o_last, want.last, want.byte_offset));
                    if (o_crc_ok !== want.crc_ok)
                        report_mismatch($sformatf("crc_ok %b, expected %b at offset %0d",
                                                  o_crc_ok, want.crc_ok, want.byte_offset));
                end
            end
        end
        o_pending = queued_payloads.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Stimulus, clock, reset and verdict for the CRC-8 checked frame receiver.
`timescale 1ns / 100ps

module tb_top;
    import crc8cfr_pkg::*;

    localparam int ITEM_GOAL   = 1900;
    localparam int NUM_PHASES  = 14;
    localparam int CYCLE_LIMIT = 500_000;
    // result shows up once its byte has passed the input and output registers; settle a little longer
    localparam int SETTLE      = 6;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_index = CFG_HEADER;
    logic [7:0] i_cfg_data  = 8'h00;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_payload_byte;
    logic [5:0] o_byte_offset;
    logic       o_last;
    logic       o_crc_ok;

    int fail_count;
    int pending;
    int checked;

    // stimulus bookkeeping
    bit         idle_on = 1'b1;
    logic [7:0] cur_header = HEADER_RESET;
    logic [6:0] cur_len    = LENGTH_RESET;
    logic [7:0] cur_seed   = SEED_RESET;
    int         byte_xfers;
    int         frame_items;
    int         frames_sent;
    int         frames_bad;
    int         cfg_sets;
    int         cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    crc8_checked_frame_receiver DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_payload_byte (o_payload_byte),
        .o_byte_offset  (o_byte_offset),
        .o_last         (o_last),
        .o_crc_ok       (o_crc_ok),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    crc8cfr_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_payload_byte (o_payload_byte),
        .o_byte_offset  (o_byte_offset),
        .o_last         (o_last),
        .o_crc_ok       (o_crc_ok),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output side back-pressure: random stall bursts while idling is on.
    always begin
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // Bit-serial CRC step used to build frames with a correct trailer.
    function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        logic       lsb;
        x = c ^ b;
        for (int k = 0; k < 8; k++) begin
            lsb = x[0];
            x   = {1'b0, x[7:1]};
            if (lsb) x = x ^ 8'h8C;
        end
        return x;
    endfunction

    // One byte transfer. Entered and left on a falling edge. An optional gap
    // (valid low) comes first; once valid is up it stays up until taken.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        byte_xfers++;
        @(negedge i_clk);
    endtask

    // Stop sending and hold off until every queued result has been taken, then wait
    // out the SETTLE delay so a byte that yields nothing has cleared the pipe.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Writes all three registers, then the unused index, on back-to-back cycles.
    // Length bit 7 is random: the register only keeps the low seven bits.
    task automatic set_config(input logic [7:0] hdr, input logic [6:0] len,
                              input logic [7:0] seed);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HEADER;
        i_cfg_data  <= hdr;
        @(negedge i_clk);
        i_cfg_index <= CFG_LENGTH;
        i_cfg_data  <= {1'($urandom_range(0, 1)), len};
        @(negedge i_clk);
        i_cfg_index <= CFG_SEED;
        i_cfg_data  <= seed;
        @(negedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= 8'($urandom_range(0, 255));
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_header = hdr;
        cur_len    = len;
        cur_seed   = seed;
        cfg_sets++;
    endtask

    // Header, random body, trailer CRC (optionally corrupted). The body sometimes
    // repeats the header value, which inside a frame is plain data.
    task automatic send_frame(input bit corrupt);
        logic [7:0] c;
        logic [7:0] d;
        int n;
        n = int'(cur_len);
        if (n > 64) n = 64;
        if (n < 2) n = 2;
        send_byte(cur_header);
        c = crc8_next(cur_seed, cur_header);
        for (int k = 1; k < n - 1; k++) begin
            d = ($urandom_range(0, 9) == 0) ? cur_header : 8'($urandom_range(0, 255));
            send_byte(d);
            c = crc8_next(c, d);
        end
        if (corrupt) c = c ^ 8'($urandom_range(1, 255));
        send_byte(c);
        frames_sent++;
        if (corrupt) frames_bad++;
        frame_items += n;
    endtask

    initial begin
        int         phase_start;
        int         r;
        logic [7:0] hdr;
        logic [6:0] len;
        logic [7:0] seed;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed ----
        // reset config: hunting drops anything that is not 0xA5
        send_byte(8'h00);
        send_byte(8'hFF);
        // frame opens; the header value right after is just payload
        send_byte(HEADER_RESET);
        send_byte(HEADER_RESET);
        send_byte(8'h3C);
        // frame still open at offset 2: cut the length below the minimum,
        // so the very next byte is taken as the trailer
        wait_quiet();
        set_config(8'h00, 7'd0, 8'h00);
        send_byte(8'h7E);
        // shortest frame, all-zero header and seed, good trailer
        send_byte(8'h00);
        send_byte(crc8_next(8'h00, 8'h00));
        // length 1 clamps to 2; all-ones header and seed, good and bad trailer
        wait_quiet();
        set_config(8'hFF, 7'd1, 8'hFF);
        send_frame(1'b0);
        send_frame(1'b1);
        // three-byte frames, good and bad
        wait_quiet();
        set_config(8'h5A, 7'd3, 8'h80);
        send_frame(1'b0);
        send_frame(1'b1);
        frame_items = 0;

        // ---- random phases ----
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_quiet();
            case (p)
                0: begin hdr = 8'hFF; len = 7'd127; seed = 8'h00; end  // clamps to 64
                1: begin hdr = 8'h00; len = 7'd64;  seed = 8'hFF; end
                default: begin
                    hdr  = ($urandom_range(0, 3) == 0) ? {8{1'($urandom_range(0, 1))}}
                                                       : 8'($urandom_range(0, 255));
                    seed = ($urandom_range(0, 3) == 0) ? {8{1'($urandom_range(0, 1))}}
                                                       : 8'($urandom_range(0, 255));
                    r = $urandom_range(0, 19);
                    if (r < 12)      len = 7'($urandom_range(2, 8));
                    else if (r < 16) len = 7'($urandom_range(9, 20));
                    else begin
                        case ($urandom_range(0, 6))
                            0:       len = 7'd0;
                            1:       len = 7'd1;
                            2:       len = 7'd2;
                            3:       len = 7'd63;
                            4:       len = 7'd64;
                            5:       len = 7'd65;
                            default: len = 7'd127;
                        endcase
                    end
                end
            endcase
            set_config(hdr, len, seed);
            // final phase runs at full rate on both sides
            idle_on     = (p == NUM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 4) != 0);
            phase_start = frame_items;
            while (frame_items - phase_start < ITEM_GOAL / NUM_PHASES) begin
                r = $urandom_range(0, 19);
                if (r < 15) begin
                    send_frame($urandom_range(0, 7) == 0);
                end else if (r < 18) begin
                    // line noise between frames
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                end else begin
                    // truncated frame: whatever follows is taken as its tail
                    send_byte(cur_header);
                    r = $urandom_range(0, 4);
                    repeat (r) send_byte(8'($urandom_range(0, 255)));
                    frame_items += r + 1;
                end
            end
        end

        wait_quiet();
        repeat (SETTLE) @(negedge i_clk);

        $display("covered %0d frames (%0d with a bad trailer), %0d byte transfers, %0d configs",
                 frames_sent, frames_bad, byte_xfers, cfg_sets);
        $display("results checked: %0d, mismatches: %0d", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- crc8_checked_frame_receiver.f -----
rtl/crc8cfr_pkg.sv
rtl/crc8cfr_cfg_regs.sv
rtl/crc8cfr_frame_fsm.sv
rtl/crc8_checked_frame_receiver.sv
tb/crc8cfr_checker.sv
tb/tb_top.sv
